// ===== hdl/rpn_integer_stack_evaluator_defines.svh =====
// Assertion macros shared by the stack evaluator modules.
`ifndef RPN_INTEGER_STACK_EVALUATOR_DEFINES_SVH
`define RPN_INTEGER_STACK_EVALUATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RPN_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RPN_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rpn_pkg.sv =====
// Shared types, codes and defaults for the stack evaluator.
`timescale 1ns / 1ps
package rpn_pkg;

  // Default sizing
  localparam int STACK_DEPTH_DEF = 64;
  localparam int DATA_WIDTH_DEF  = 32;

  // Field widths
  localparam int ACTION_W   = 2;
  localparam int OPERAND_W  = 31;
  localparam int OPCODE_W   = 3;
  localparam int RESULT_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // Token kinds
  localparam logic [ACTION_W-1:0] ACT_NUMBER   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_OPERATOR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_END      = 2'd2;

  // Operator codes
  localparam logic [OPCODE_W-1:0] OP_ADD = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SUB = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_MUL = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DIV = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REM = 3'd4;

  // End-of-expression status
  localparam logic [STATUS_W-1:0] ST_VALID    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic                push;       // write operand at count, count up
    logic                set_ovf;    // mark overflow and invalid
    logic                set_inv;    // mark invalid
    logic                rd_en;      // read stack
    logic                rd_second;  // read second entry instead of top
    logic                ld_right;   // capture read data as right operand
    logic                ld_left;    // capture read data as left operand
    logic                pop2;       // drop two entries
    logic                alu_init;   // load serial unit
    logic                alu_step;   // one serial iteration
    logic                wr_res;     // write result at count, count up
    logic                end_load;   // load output, clear stack and flags
    logic [OPCODE_W-1:0] op;         // operator in flight
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic count_lt2;
    logic count_full;
    logic expr_valid;
    logic right_zero;
    logic out_busy;
  } stat_t;

endpackage

// ===== hdl/rpn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/rpn_ctrl.sv =====
// Token sequencer: decodes requests and steps the datapath.
`timescale 1ns / 1ps
`include "rpn_integer_stack_evaluator_defines.svh"
module rpn_ctrl
  import rpn_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [OPCODE_W-1:0] in_code,
  input  stat_t               stat,
  output cmd_t                cmd
);

  localparam int IW = $clog2(DATA_WIDTH);
  localparam logic [IW-1:0] ITER_LAST = IW'(DATA_WIDTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDB  = 3'd1;
  localparam logic [2:0] S_RDA  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_ITER = 3'd4;
  localparam logic [2:0] S_FIX  = 3'd5;
  localparam logic [2:0] S_END  = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [IW-1:0]       iter_r, iter_nxt;
  logic [OPCODE_W-1:0] code_r;
  logic                accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Hold the operator of the request in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      code_r <= in_code;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    cmd.op    = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_action)
            ACT_END: begin
              cmd.rd_en = 1'b1;
              state_nxt = S_END;
            end
            ACT_NUMBER: begin
              if (stat.expr_valid) begin
                cmd.set_ovf = stat.count_full;
                cmd.push    = !stat.count_full;
              end
            end
            ACT_OPERATOR: begin
              if (stat.expr_valid) begin
                if (stat.count_lt2) begin
                  cmd.set_inv = 1'b1;
                end else begin
                  cmd.rd_en = 1'b1;
                  state_nxt = S_RDB;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RDB: begin
        cmd.ld_right  = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_second = 1'b1;
        state_nxt     = S_RDA;
      end
      S_RDA: begin
        cmd.ld_left = 1'b1;
        cmd.pop2    = 1'b1;
        state_nxt   = S_PREP;
      end
      S_PREP: begin
        state_nxt = S_IDLE;
        case (code_r)
          OP_ADD, OP_SUB: begin
            cmd.wr_res = 1'b1;
          end
          OP_MUL: begin
            cmd.alu_init = 1'b1;
            iter_nxt     = '0;
            state_nxt    = S_ITER;
          end
          OP_DIV, OP_REM: begin
            if (!stat.right_zero) begin
              cmd.alu_init = 1'b1;
              iter_nxt     = '0;
              state_nxt    = S_ITER;
            end
          end
          default: ;
        endcase
      end
      S_ITER: begin
        cmd.alu_step = 1'b1;
        if (iter_r == ITER_LAST) begin
          iter_nxt  = '0;
          state_nxt = S_FIX;
        end else begin
          iter_nxt = iter_r + IW'(1);
        end
      end
      S_FIX: begin
        cmd.wr_res = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_END: begin
        if (!stat.out_busy) begin
          cmd.end_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // Stack writes and the end load never coincide
  `RPN_ASSERT_NOW(a_one_write, 1'b1, $onehot0({cmd.push, cmd.wr_res, cmd.end_load}), "write clash")
  // Iteration count runs only inside the serial loop
  `RPN_ASSERT_NOW(a_iter_idle, iter_r != '0, state_r == S_ITER, "stray iteration count")
  // A finished serial run always writes its result next
  `RPN_ASSERT_NEXT(a_iter_done, state_r == S_ITER && iter_r == ITER_LAST, cmd.wr_res, "no result write")

endmodule

// ===== hdl/rpn_dpath.sv =====
// Stack datapath: operand store, count and flags, serial multiply/divide, output register.
`timescale 1ns / 1ps
`include "rpn_integer_stack_evaluator_defines.svh"
module rpn_dpath
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic [OPERAND_W-1:0] operand_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RESULT_W-1:0]  result_value,
  output logic [STATUS_W-1:0]  status
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int W  = DATA_WIDTH;

  logic [CW-1:0]       count_r, count_nxt;
  logic                valid_r, valid_nxt;
  logic                ovf_r, ovf_nxt;
  logic [W-1:0]        left_r, right_r;
  logic [W-1:0]        acc_r, acc_nxt;
  logic [W-1:0]        quo_r, quo_nxt;
  logic [W-1:0]        dv_r, dv_nxt;
  logic [W:0]          trial;
  logic [W-1:0]        res;
  logic [W-1:0]        rd_data;
  logic [AW-1:0]       rd_addr;
  logic [W-1:0]        wr_data;
  logic                left_neg, right_neg;
  logic                out_valid_r;
  logic [RESULT_W-1:0] out_data_r;
  logic [STATUS_W-1:0] out_status_r;

  // Operand store
  assign rd_addr = cmd.rd_second ? AW'(count_r - CW'(2)) : AW'(count_r - CW'(1));
  assign wr_data = cmd.push ? W'(operand_value) : res;

  rpn_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.push || cmd.wr_res),
    .wr_addr (AW'(count_r)),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Capture operands
  always_ff @(posedge clk) begin
    if (cmd.ld_right) begin
      right_r <= rd_data;
    end
    if (cmd.ld_left) begin
      left_r <= rd_data;
    end
  end

  assign left_neg  = left_r[W-1];
  assign right_neg = right_r[W-1];

  // Serial unit: shift-add multiply, or restoring divide on magnitudes
  always_comb begin
    acc_nxt = acc_r;
    quo_nxt = quo_r;
    dv_nxt  = dv_r;
    trial   = {acc_r, quo_r[W-1]} - {1'b0, dv_r};
    if (cmd.alu_init) begin
      acc_nxt = '0;
      if (cmd.op == OP_MUL) begin
        quo_nxt = left_r;
        dv_nxt  = right_r;
      end else begin
        quo_nxt = left_neg ? W'(0) - left_r : left_r;
        dv_nxt  = right_neg ? W'(0) - right_r : right_r;
      end
    end else if (cmd.alu_step) begin
      if (cmd.op == OP_MUL) begin
        if (dv_r[0]) begin
          acc_nxt = acc_r + quo_r;
        end
        quo_nxt = {quo_r[W-2:0], 1'b0};
        dv_nxt  = {1'b0, dv_r[W-1:1]};
      end else if (!trial[W]) begin
        acc_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        acc_nxt = {acc_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
    dv_r  <= dv_nxt;
  end

  // Result select with sign fix-up
  always_comb begin
    case (cmd.op)
      OP_ADD:  res = left_r + right_r;
      OP_SUB:  res = left_r - right_r;
      OP_MUL:  res = acc_r;
      OP_DIV:  res = (left_neg != right_neg) ? W'(0) - quo_r : quo_r;
      OP_REM:  res = left_neg ? W'(0) - acc_r : acc_r;
      default: res = '0;
    endcase
  end

  // Count and expression flags
  always_comb begin
    count_nxt = count_r;
    valid_nxt = valid_r;
    ovf_nxt   = ovf_r;
    if (cmd.end_load) begin
      count_nxt = '0;
      valid_nxt = 1'b1;
      ovf_nxt   = 1'b0;
    end else begin
      if (cmd.pop2) begin
        count_nxt = count_r - CW'(2);
      end else if (cmd.push || cmd.wr_res) begin
        count_nxt = count_r + CW'(1);
      end
      if (cmd.set_ovf) begin
        ovf_nxt   = 1'b1;
        valid_nxt = 1'b0;
      end
      if (cmd.set_inv) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b1;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.end_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.end_load) begin
      out_data_r <= '0;
      if (ovf_r) begin
        out_status_r <= ST_OVERFLOW;
      end else if (!valid_r) begin
        out_status_r <= ST_FEW;
      end else if (count_r == '0) begin
        out_status_r <= ST_EMPTY;
      end else begin
        out_status_r <= ST_VALID;
        out_data_r   <= RESULT_W'(rd_data);
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign result_value = out_data_r;
  assign status       = out_status_r;

  // Status to the controller
  assign stat.count_lt2  = (count_r < CW'(2));
  assign stat.count_full = (count_r == CW'(STACK_DEPTH));
  assign stat.expr_valid = valid_r;
  assign stat.right_zero = (right_r == '0);
  assign stat.out_busy   = out_valid_r && !out_ready;

  // Count never passes the depth
  `RPN_ASSERT_NOW(a_count_range, 1'b1, count_r <= CW'(STACK_DEPTH), "stack count out of range")
  // Overflow always leaves the expression invalid
  `RPN_ASSERT_NOW(a_ovf_inv, ovf_r, !valid_r, "overflow without invalid")
  // End of expression restores a clean stack
  `RPN_ASSERT_NEXT(a_end_clear, cmd.end_load, count_r == '0 && valid_r && !ovf_r && out_valid_r,
                   "stack not cleared")

endmodule

// ===== hdl/rpn_integer_stack_evaluator.sv =====
// Top level of the integer reverse-Polish stack evaluator.
// One request is a token: a number pushes its value, an operator pops two
// operands and pushes the result, an end token returns the top of stack (or
// why the expression failed) and empties the stack. Tokens are taken one at
// a time. A number or an ignored token is handled as it is taken. Add and
// subtract read both operands through the single read port of the stack
// RAM, then write back, and an operator that only drops its operands (a
// zero divisor or an unknown operator) makes the same reads. Multiply,
// divide and remainder also run the one-bit-per-cycle shift-add and
// restoring divide unit before the write back, and an end token waits for
// the output register to be free. A new token is taken while a result still
// waits at the output. The stack needs no clearing pass after reset.
`timescale 1ns / 1ps
module rpn_integer_stack_evaluator
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // operand_value[30:0], operator_code[33:31], zeros
  input  logic [ACTION_W-1:0]   in_tuser,   // action[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // result_value[31:0]
  output logic [STATUS_W-1:0]   out_tuser   // status[1:0]
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  rpn_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .in_code   (in_tdata[OPERAND_W +: OPCODE_W]),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Stack, arithmetic and output register
  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .operand_value (in_tdata[OPERAND_W-1:0]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .result_value  (out_tdata),
    .status        (out_tuser)
  );

endmodule

// ===== test/tb_rpn_integer_stack_evaluator.sv =====
// Self-checking regression bench for the integer reverse-Polish stack evaluator.
`timescale 1ns / 1ps
module tb_rpn_integer_stack_evaluator;
  import rpn_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;
  localparam logic [OPCODE_W-1:0] OP_OTHER    = 3'd5;

  localparam logic [OPERAND_W-1:0] OPERAND_MAX = {OPERAND_W{1'b1}};
  localparam int IDLE_PCT       = 28;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 60;

  typedef struct packed {
    logic [RESULT_W-1:0] value;
    logic [STATUS_W-1:0] status;
  } end_report_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [ACTION_W-1:0]   in_tuser   = ACT_NUMBER;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // Evaluator state as the bench expects it
  logic [RESULT_W-1:0] operand_mem [STACK_DEPTH_DEF];
  int                  depth_now = 0;
  bit                  expr_ok   = 1'b1;
  bit                  ovf_seen  = 1'b0;
  end_report_t         pending_reports [$];

  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_request = 1'b0;
  int errors          = 0;
  int tokens_sent     = 0;
  int live_tokens     = 0;
  int reports_checked = 0;
  int quiet_cycles    = 0;

  always #5 clk = ~clk;

  rpn_integer_stack_evaluator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Apply one operator; return 0 when both operands are simply dropped
  function automatic bit combine_operands(input logic [OPCODE_W-1:0] code,
                                          input logic [RESULT_W-1:0] lhs,
                                          input logic [RESULT_W-1:0] rhs,
                                          output logic [RESULT_W-1:0] res);
    logic [RESULT_W-1:0] lmag, rmag;
    lmag = lhs[RESULT_W-1] ? -lhs : lhs;
    rmag = rhs[RESULT_W-1] ? -rhs : rhs;
    res  = '0;
    case (code)
      OP_ADD: res = lhs + rhs;
      OP_SUB: res = lhs - rhs;
      OP_MUL: res = lhs * rhs;
      OP_DIV: begin
        if (rhs == '0) return 1'b0;
        res = lmag / rmag;
        if (lhs[RESULT_W-1] ^ rhs[RESULT_W-1]) res = -res;
      end
      OP_REM: begin
        if (rhs == '0) return 1'b0;
        res = lmag % rmag;
        if (lhs[RESULT_W-1]) res = -res;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Advance the expected state by one accepted token; return 0 if it was ignored
  function automatic bit apply_token(input logic [ACTION_W-1:0] act,
                                     input logic [OPERAND_W-1:0] val,
                                     input logic [OPCODE_W-1:0] code);
    end_report_t         rep;
    logic [RESULT_W-1:0] lhs, rhs, res;
    if (act == ACT_END) begin
      rep.value = '0;
      if (ovf_seen) rep.status = ST_OVERFLOW;
      else if (!expr_ok) rep.status = ST_FEW;
      else if (depth_now == 0) rep.status = ST_EMPTY;
      else begin
        rep.status = ST_VALID;
        rep.value  = operand_mem[depth_now-1];
      end
      pending_reports.push_back(rep);
      depth_now = 0;
      expr_ok   = 1'b1;
      ovf_seen  = 1'b0;
      return 1'b1;
    end
    if (!expr_ok || act == ACT_IGNORED) return 1'b0;
    if (act == ACT_NUMBER) begin
      if (depth_now >= STACK_DEPTH_DEF) begin
        ovf_seen = 1'b1;
        expr_ok  = 1'b0;
      end else begin
        operand_mem[depth_now] = {1'b0, val};
        depth_now++;
      end
    end else if (depth_now < 2) begin
      expr_ok = 1'b0;
    end else begin
      rhs = operand_mem[depth_now-1];
      lhs = operand_mem[depth_now-2];
      depth_now -= 2;
      if (combine_operands(code, lhs, rhs, res)) begin
        operand_mem[depth_now] = res;
        depth_now++;
      end
    end
    return 1'b1;
  endfunction

  // Offer one request and hold it until accepted; valid stays high afterwards
  task automatic send_token(input logic [ACTION_W-1:0] act,
                            input logic [OPERAND_W-1:0] val,
                            input logic [OPCODE_W-1:0] code);
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_DATA_W-OPERAND_W-OPCODE_W){1'b0}}, code, val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tokens_sent++;
    if (apply_token(act, val, code)) live_tokens++;
  endtask

  task automatic push_number(input logic [OPERAND_W-1:0] val);
    send_token(ACT_NUMBER, val, OPCODE_W'($urandom_range(7)));
  endtask

  task automatic apply_operator(input logic [OPCODE_W-1:0] code);
    send_token(ACT_OPERATOR, OPERAND_W'($urandom), code);
  endtask

  task automatic close_expression();
    send_token(ACT_END, OPERAND_W'($urandom), OPCODE_W'($urandom_range(7)));
  endtask

  // Mix extremes with small values so divides and remainders stay interesting
  function automatic logic [OPERAND_W-1:0] pick_operand();
    case ($urandom_range(9))
      0:       return '0;
      1:       return OPERAND_W'(1);
      2:       return OPERAND_MAX;
      3, 4:    return OPERAND_W'($urandom_range(15));
      5, 6:    return OPERAND_W'($urandom_range(1000));
      default: return OPERAND_W'($urandom);
    endcase
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_opcode();
    if ($urandom_range(99) < 90) return OPCODE_W'($urandom_range(OP_REM));
    return OPCODE_W'($urandom_range(7, OP_OTHER));
  endfunction

  // One expression; a broken one may lead with an operator or carry stray tokens
  task automatic run_expression(input int length, input int push_pct, input bit broken);
    int depth, k;
    depth = 0;
    if (broken && $urandom_range(1)) apply_operator(pick_opcode());
    for (k = 0; k < length; k++) begin
      if (broken && $urandom_range(9) == 0)
        send_token(ACT_IGNORED, OPERAND_W'($urandom), OPCODE_W'($urandom_range(7)));
      if (depth < 2 || $urandom_range(99) < push_pct) begin
        push_number(pick_operand());
        depth++;
      end else begin
        apply_operator(pick_opcode());
        depth--;
      end
    end
    close_expression();
  endtask

  task automatic test_arithmetic_chain();
    // ((MAX + MAX) * 5 / 3 % 2) - 7 walks every operator through negative values
    push_number(OPERAND_MAX);
    push_number(OPERAND_MAX);
    apply_operator(OP_ADD);
    push_number(OPERAND_W'(5));
    apply_operator(OP_MUL);
    push_number(OPERAND_W'(3));
    apply_operator(OP_DIV);
    push_number(OPERAND_W'(2));
    apply_operator(OP_REM);
    push_number(OPERAND_W'(7));
    apply_operator(OP_SUB);
    close_expression();
  endtask

  task automatic test_most_negative_division();
    int k;
    for (k = 0; k < 2; k++) begin
      // Build the most negative value, then -1, then divide or take remainder
      push_number(OPERAND_W'(0));
      push_number(OPERAND_MAX);
      apply_operator(OP_SUB);
      push_number(OPERAND_W'(1));
      apply_operator(OP_SUB);
      push_number(OPERAND_W'(0));
      push_number(OPERAND_W'(1));
      apply_operator(OP_SUB);
      apply_operator(k == 0 ? OP_DIV : OP_REM);
      close_expression();
    end
  endtask

  task automatic test_discarding_operators();
    // Zero divisors and unknown operators drop both operands; 4 is left over
    push_number(OPERAND_W'(4));
    push_number(OPERAND_W'(5));
    push_number(OPERAND_W'(0));
    apply_operator(OP_DIV);
    push_number(OPERAND_W'(6));
    push_number(OPERAND_W'(0));
    apply_operator(OP_REM);
    push_number(OPERAND_W'(1));
    push_number(OPERAND_W'(2));
    apply_operator(OP_OTHER);
    send_token(ACT_IGNORED, OPERAND_MAX, OP_ADD);
    close_expression();
  endtask

  task automatic test_invalid_and_empty();
    // Operator on an empty stack, then a token that must be ignored
    apply_operator(OP_ADD);
    push_number(OPERAND_W'(9));
    close_expression();
    // End with nothing on the stack
    close_expression();
    // Too few operands after a partial evaluation
    push_number(OPERAND_W'(1));
    push_number(OPERAND_W'(2));
    apply_operator(OP_ADD);
    apply_operator(OP_MUL);
    close_expression();
  endtask

  task automatic test_stack_full();
    int k;
    // Exactly full is still a valid expression
    for (k = 0; k < STACK_DEPTH_DEF; k++) push_number(OPERAND_W'($urandom));
    close_expression();
    // One push past full flags overflow, and later tokens are ignored
    for (k = 0; k <= STACK_DEPTH_DEF; k++) push_number(OPERAND_W'($urandom));
    apply_operator(OP_ADD);
    close_expression();
  endtask

  task automatic test_output_backpressure();
    int k;
    // Result side holds off while short expressions keep coming
    hold_request = 1'b1;
    for (k = 0; k < 12; k++) run_expression($urandom_range(2, 4), 60, 1'b0);
    while (hold_request) @(posedge clk);
  endtask

  task automatic test_random_expressions(input int upto);
    while (live_tokens < upto) begin
      if ($urandom_range(99) < 3)
        run_expression($urandom_range(60, 72), 95, 1'b0);
      else
        run_expression($urandom_range(0, 14), 50, $urandom_range(99) < 12);
    end
  endtask

  task automatic test_back_to_back(input int upto);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_expressions(upto);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // Result side ready, with random stalls and one long hold-off on request
  initial begin : result_sink
    int held;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_request = 1'b0;
      end else if (sink_idle_en) begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted report with the oldest expectation
  always @(posedge clk) begin : report_checker
    end_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("report with no expectation: result_value %0d status %0d",
               $signed(out_tdata), out_tuser);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (out_tdata !== want.value) begin
          $error("result_value: expected %0d, got %0d", $signed(want.value), $signed(out_tdata));
          errors++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          errors++;
        end
      end
    end
  end

  // End the run when no request moves on either side for too long
  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : regression
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_arithmetic_chain();
    test_most_negative_division();
    test_discarding_operators();
    test_invalid_and_empty();
    test_stack_full();
    test_output_backpressure();
    test_random_expressions(600);
    test_back_to_back(850);
    test_random_expressions(1050);
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected reports never arrived", pending_reports.size());
      errors++;
    end
    $display("covered %0d tokens (%0d not ignored), %0d end reports checked", tokens_sent,
             live_tokens, reports_checked);
    $display("all operators, dropped operands, invalid, empty and overflowed stacks, stalls");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
